// ----- sv/tgarle_pkg.sv -----
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Shared constants and register codes for the Targa pixel data decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  // Default width of the image pixel counter.
  localparam int unsigned PixelCountBitsDef = 25;

  // Field widths.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ImgW     = 25;
  localparam int unsigned PixBytesW = 3;
  localparam int unsigned OutDataW = 40;

  // Packet header handling: a run header carries the count plus 127.
  localparam logic [ByteW-1:0] RunBias = 8'd127;

  // Register reset values.
  localparam logic [PixBytesW-1:0] PixBytesRst = 3'd3;
  localparam logic [ImgW-1:0]      ImgPixRst   = 25'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIXEL_BYTES   = 2'd0,
    CFG_RLE_MODE      = 2'd1,
    CFG_SWAP_RED_BLUE = 2'd2,
    CFG_IMAGE_PIXELS  = 2'd3
  } cfg_reg_e;

endpackage

// ----- sv/tga_rle_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Turns Targa pixel data bytes into pixels with repeat counts.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one pixel data byte per transfer (header already
// parsed by software). The master stream gives one pixel per transfer:
// tdata holds the four components and the repeat count, tlast marks the
// pixel that reaches the end of the image and tuser flags a clipped packet.
// The configuration channel writes bytes per pixel, the run-length mode,
// the red/blue swap and the image pixel count; it is always ready. The
// user must write it only while the block is idle; the block itself does
// not enforce this. One byte is accepted every cycle while the output
// register is free or being read. A pixel appears on the master side in
// the cycle after the transfer of its last byte; packet headers and partial
// pixel bytes give no output. All per-byte work is a byte insert, a
// subtract and a compare against the image pixel counter, done in the
// cycle the byte is accepted, and the result is held in one output register.
// When the receiver stalls, the output register holds its pixel and the
// byte input stays ready only while that register is free or being read
// in the same cycle. Reset clears the decoding state and loads the
// register defaults: 3 bytes per pixel, run-length mode, swap on, 1 pixel.
// At the end of the image all decoding state returns to its reset value.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
  parameter int unsigned PIXEL_COUNT_BITS = tgarle_pkg::PixelCountBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tgarle_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tgarle_pkg::CfgDataW-1:0]   cfg_data_i,
  // Byte input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tgarle_pkg::ByteW-1:0]      s_axis_tdata,   // data_byte
  // Pixel output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tgarle_pkg::OutDataW-1:0]   m_axis_tdata,   // comp0, comp1, comp2,
                                                            // comp3, repeat_res
  output logic                              m_axis_tlast,   // last_pixel
  output logic                              m_axis_tuser    // overrun
);

  localparam int unsigned CntW  = PIXEL_COUNT_BITS;
  localparam int unsigned ByteW = tgarle_pkg::ByteW;

  // Configuration registers.
  logic [tgarle_pkg::PixBytesW-1:0] pix_bytes_q;
  logic                             rle_mode_q;
  logic                             swap_q;
  logic [tgarle_pkg::ImgW-1:0]      img_pix_q;

  // Decoding state.
  logic [1:0]        slot_q, slot_d;
  logic              is_run_q, is_run_d;
  logic [ByteW-1:0]  left_q, left_d;
  logic [31:0]       part_q, part_d;
  logic [CntW-1:0]   done_q, done_d;

  // Output register.
  logic              out_valid_q;
  logic [ByteW-1:0]  comp0_q, comp1_q, comp2_q, comp3_q, rep_q;
  logic              last_q, over_q;

  // Combinational results.
  logic              in_acc;
  logic              res_valid;
  logic [ByteW-1:0]  comp0_d, comp1_d, comp2_d, comp3_d, rep_d;
  logic              last_d, over_d;

  logic              four_bytes;
  logic [ByteW-1:0]  rep_raw;
  logic              owed_more;
  logic [CntW+tgarle_pkg::ImgW-1:0] img_wide;
  logic [CntW-1:0]   total;
  logic [CntW-1:0]   remaining;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign four_bytes    = (pix_bytes_q == 3'd4);

  // The pixel count is taken modulo the counter width; zero means one pixel.
  assign img_wide = (CntW + tgarle_pkg::ImgW)'(img_pix_q);
  always_comb begin
    total = img_wide[CntW-1:0];
    if (total == '0) begin
      total = CntW'(1);
    end
  end
  assign remaining = (total > done_q) ? (total - done_q) : CntW'(1);

  always_comb begin
    slot_d    = slot_q;
    is_run_d  = is_run_q;
    left_d    = left_q;
    part_d    = part_q;
    done_d    = done_q;
    res_valid = 1'b0;
    rep_raw   = 8'd1;
    owed_more = 1'b0;
    last_d    = 1'b0;
    over_d    = 1'b0;
    rep_d     = 8'd1;
    comp0_d   = '0;
    comp1_d   = '0;
    comp2_d   = '0;
    comp3_d   = '0;

    if (rle_mode_q && (left_q == '0)) begin
      // Packet header: bit 7 selects a run.
      is_run_d = s_axis_tdata[7];
      left_d   = s_axis_tdata[7] ? (s_axis_tdata - tgarle_pkg::RunBias)
                                 : (s_axis_tdata + 8'd1);
    end else begin
      part_d[{slot_q, 3'b000} +: 8] = s_axis_tdata;
      if ((slot_q < 2'd2) || ((slot_q == 2'd2) && four_bytes)) begin
        slot_d = slot_q + 2'd1;
      end else begin
        res_valid = 1'b1;
        comp0_d   = swap_q ? part_d[23:16] : part_d[7:0];
        comp1_d   = part_d[15:8];
        comp2_d   = swap_q ? part_d[7:0] : part_d[23:16];
        comp3_d   = four_bytes ? part_d[31:24] : 8'd0;
        slot_d    = '0;
        part_d    = '0;

        if (rle_mode_q) begin
          if (is_run_q) begin
            rep_raw = left_q;
            left_d  = '0;
          end else begin
            left_d    = left_q - 8'd1;
            owed_more = (left_d != '0);
          end
        end

        last_d = (CntW'(rep_raw) >= remaining);
        if (last_d) begin
          over_d   = (CntW'(rep_raw) > remaining) || owed_more;
          rep_d    = remaining[ByteW-1:0];
          // End of image: back to the start state.
          slot_d   = '0;
          is_run_d = 1'b0;
          left_d   = '0;
          done_d   = '0;
        end else begin
          rep_d  = rep_raw;
          done_d = done_q + CntW'(rep_raw);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_bytes_q <= tgarle_pkg::PixBytesRst;
      rle_mode_q  <= 1'b1;
      swap_q      <= 1'b1;
      img_pix_q   <= tgarle_pkg::ImgPixRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tgarle_pkg::cfg_reg_e'(cfg_index_i))
        tgarle_pkg::CFG_PIXEL_BYTES:   pix_bytes_q <= cfg_data_i[tgarle_pkg::PixBytesW-1:0];
        tgarle_pkg::CFG_RLE_MODE:      rle_mode_q  <= cfg_data_i[0];
        tgarle_pkg::CFG_SWAP_RED_BLUE: swap_q      <= cfg_data_i[0];
        tgarle_pkg::CFG_IMAGE_PIXELS:  img_pix_q   <= cfg_data_i[tgarle_pkg::ImgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      is_run_q <= 1'b0;
      left_q   <= '0;
      part_q   <= '0;
      done_q   <= '0;
    end else if (in_acc) begin
      slot_q   <= slot_d;
      is_run_q <= is_run_d;
      left_q   <= left_d;
      part_q   <= part_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= in_acc && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      comp0_q <= comp0_d;
      comp1_q <= comp1_d;
      comp2_q <= comp2_d;
      comp3_q <= comp3_d;
      rep_q   <= rep_d;
      last_q  <= last_d;
      over_q  <= over_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {rep_q, comp3_q, comp2_q, comp1_q, comp0_q};
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = over_q;

`ifndef SYNTH
  // A clipped packet is always the one that ends the image.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("overrun flagged on a pixel that does not end the image");

  // Every pixel delivered stands for at least one image pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:32] != 8'd0))
    else $error("zero repeat count on output");

  // Reaching the end of the image clears the pixel counter and the packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_valid && last_d) |=> ((done_q == '0) && (left_q == '0)))
    else $error("decoding state not cleared at end of image");
`endif

endmodule

// ----- sim/tga_rle_pixel_decoder_test.sv -----
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Streams Targa pixel data bytes into the decoder under random handshake
// gaps on both sides. A predictor in the bench follows the packet and pixel
// state byte by byte and holds the expected pixels in a queue. Every pixel
// transfer on the master side is checked against that queue, field by field.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_test;
  import tgarle_pkg::*;

  localparam int unsigned ByteTarget = 960;
  localparam logic [ImgW-1:0] ImgMax = 25'd16777216;

  typedef struct {
    logic [7:0] comp0;
    logic [7:0] comp1;
    logic [7:0] comp2;
    logic [7:0] comp3;
    logic [7:0] repeat_cnt;
    logic       last_pixel;
    logic       overrun;
  } pixel_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;   // data_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // comp0, comp1, comp2, comp3, repeat_res
  logic                m_axis_tlast;   // last_pixel
  logic                m_axis_tuser;   // overrun

  // Register copies, at their reset values.
  logic [PixBytesW-1:0] pix_bytes = PixBytesRst;
  logic                 rle_on    = 1'b1;
  logic                 swap_rb   = 1'b1;
  logic [ImgW-1:0]      img_size  = ImgPixRst;

  // Decoder state as the predictor sees it.
  int unsigned     slot      = 0;
  logic            run_pkt   = 1'b0;
  logic [7:0]      owed_left = 8'd0;
  logic [31:0]     gather    = 32'd0;
  logic [ImgW-1:0] done_cnt  = '0;

  pixel_t pending_pixels[$];

  int unsigned errors      = 0;
  int unsigned bytes_sent  = 0;
  int unsigned pixels_seen = 0;
  int unsigned ends_seen   = 0;
  int unsigned clips_seen  = 0;
  int unsigned reg_writes  = 0;
  bit          quiet       = 1'b0;

  tga_rle_pixel_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Mostly short gaps, a few long ones; none at all during a quiet stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_decoder();
    slot      = 0;
    run_pkt   = 1'b0;
    owed_left = 8'd0;
    gather    = 32'd0;
    done_cnt  = '0;
  endfunction

  // Advances the predicted decoder by one accepted byte.
  function automatic void decode_byte(input logic [7:0] b);
    pixel_t          px;
    int unsigned     npb;
    int unsigned     rep;
    logic [ImgW-1:0] total;
    logic [ImgW-1:0] remaining;
    logic [31:0]     word;
    bit              owed;
    bit              last;
    owed = 1'b0;
    if (rle_on && owed_left == 8'd0) begin
      // Packet header: a run carries its count plus 127, a literal its count minus one.
      run_pkt   = b[7];
      owed_left = b[7] ? b - RunBias : b + 8'd1;
      return;
    end
    npb = (pix_bytes == 3'd4) ? 4 : 3;
    gather[8*slot +: 8] = b;
    if (slot + 1 < npb) begin
      slot++;
      return;
    end
    word   = gather;
    slot   = 0;
    gather = 32'd0;
    if (!rle_on) begin
      rep = 1;
    end else if (run_pkt) begin
      rep       = owed_left;
      owed_left = 8'd0;
    end else begin
      rep       = 1;
      owed_left = owed_left - 8'd1;
      owed      = (owed_left != 8'd0);
    end
    total     = (img_size == '0) ? ImgW'(1) : img_size;
    remaining = (total > done_cnt) ? total - done_cnt : ImgW'(1);
    last      = (rep >= remaining);
    px.overrun = last && (rep > remaining || owed);
    if (last) begin
      rep = remaining;
      clear_decoder();
    end else begin
      done_cnt = done_cnt + ImgW'(rep);
    end
    px.comp0      = swap_rb ? word[23:16] : word[7:0];
    px.comp1      = word[15:8];
    px.comp2      = swap_rb ? word[7:0] : word[23:16];
    px.comp3      = (npb == 4) ? word[31:24] : 8'd0;
    px.repeat_cnt = rep[7:0];
    px.last_pixel = last;
    pending_pixels.push_back(px);
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      pixels_seen++;
      if (m_axis_tlast) ends_seen++;
      if (m_axis_tuser) clips_seen++;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h last %b overrun %b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("comp0", want.comp0, m_axis_tdata[7:0]);
        check_field("comp1", want.comp1, m_axis_tdata[15:8]);
        check_field("comp2", want.comp2, m_axis_tdata[23:16]);
        check_field("comp3", want.comp3, m_axis_tdata[31:24]);
        check_field("repeat_res", want.repeat_cnt, m_axis_tdata[39:32]);
        check_field("last_pixel", want.last_pixel, m_axis_tlast);
        check_field("overrun", want.overrun, m_axis_tuser);
      end
    end
  end

  initial begin : pixel_sink
    int unsigned n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = pick_gap();
      if (n != 0) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  // Valid stays high from one transfer to the next unless a gap is drawn.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_random_bytes(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Waits until every expected pixel has come, then lets the pipeline settle.
  task automatic drain_pixels();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PIXEL_BYTES:   pix_bytes = value[PixBytesW-1:0];
      CFG_RLE_MODE:      rle_on    = value[0];
      CFG_SWAP_RED_BLUE: swap_rb   = value[0];
      CFG_IMAGE_PIXELS:  img_size  = value[ImgW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One-pixel image at reset: exact fit, clipped run, literal packet still owing.
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33);
    send_byte(8'hFF);
    send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);
    send_byte(8'h7F);
    send_byte(8'hFF); send_byte(8'hFE); send_byte(8'hFD);
  endtask

  // Raw 4-byte pixel, no swap, into an image of size zero.
  task automatic test_raw_zero_size();
    drain_pixels();
    write_reg(CFG_IMAGE_PIXELS, 32'd0);
    write_reg(CFG_RLE_MODE, 32'd0);
    write_reg(CFG_SWAP_RED_BLUE, 32'd0);
    write_reg(CFG_PIXEL_BYTES, 32'd4);
    send_byte(8'h01); send_byte(8'h80); send_byte(8'h7F); send_byte(8'hFE);
  endtask

  // The image size is lowered below the count reached so far.
  task automatic test_size_lowered();
    drain_pixels();
    write_reg(CFG_IMAGE_PIXELS, 32'd10);
    write_reg(CFG_RLE_MODE, 32'd1);
    write_reg(CFG_SWAP_RED_BLUE, 32'd1);
    write_reg(CFG_PIXEL_BYTES, 32'd3);
    send_byte(8'h87);
    send_byte(8'hAA); send_byte(8'h55); send_byte(8'h0F);
    drain_pixels();
    write_reg(CFG_IMAGE_PIXELS, 32'd5);
    send_byte(8'h00);
    send_byte(8'hF0); send_byte(8'h0F); send_byte(8'h5A);
  endtask

  // Run-length mode turned on with two pixel bytes pending: the next byte
  // is a header and the pending bytes are kept.
  task automatic test_mode_switch_mid_pixel();
    drain_pixels();
    write_reg(CFG_RLE_MODE, 32'd0);
    send_byte(8'hC3); send_byte(8'h3C);
    drain_pixels();
    write_reg(CFG_RLE_MODE, 32'd1);
    send_byte(8'h00);
    send_byte(8'h99);
  endtask

  // Pixel size lowered from four to three with three bytes gathered.
  task automatic test_pixel_size_lowered();
    drain_pixels();
    write_reg(CFG_RLE_MODE, 32'd0);
    write_reg(CFG_PIXEL_BYTES, 32'd4);
    send_byte(8'h12); send_byte(8'h34); send_byte(8'h56);
    drain_pixels();
    write_reg(CFG_PIXEL_BYTES, 32'd3);
    send_byte(8'h78);
  endtask

  // Phases of well-formed packets with random content under random settings,
  // with some stray bytes mixed in.
  task automatic test_random_stream();
    int unsigned     phase;
    int unsigned     stop_at;
    int unsigned     npb;
    int unsigned     cnt;
    int unsigned     r;
    logic [ImgW-1:0] img;
    phase = 0;
    while (bytes_sent < ByteTarget) begin
      drain_pixels();
      r = $urandom_range(0, 99);
      if (phase == 0) img = ImgW'(1);
      else if (phase == 1) img = ImgMax;
      else if (r < 40) img = ImgW'($urandom_range(1, 8));
      else if (r < 75) img = ImgW'($urandom_range(9, 200));
      else if (r < 90) img = ImgW'($urandom_range(201, 16777216));
      else img = ImgMax - ImgW'($urandom_range(0, 3));
      write_reg(CFG_IMAGE_PIXELS, 32'(img));
      write_reg(CFG_PIXEL_BYTES, (phase == 1 || (phase > 1 && $urandom_range(0, 1) == 1))
                                 ? 32'd4 : 32'd3);
      write_reg(CFG_RLE_MODE, ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);
      write_reg(CFG_SWAP_RED_BLUE, 32'($urandom_range(0, 1)));
      quiet   = ($urandom_range(0, 3) == 0);
      npb     = (pix_bytes == 3'd4) ? 4 : 3;
      stop_at = bytes_sent + $urandom_range(30, 110);
      while (bytes_sent < stop_at && bytes_sent < ByteTarget) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_random_bytes($urandom_range(1, 5));
        end else if (!rle_on) begin
          send_random_bytes(npb);
        end else if (r < 55) begin
          cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
          send_byte(8'(cnt + 127));
          send_random_bytes(npb);
        end else begin
          cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
          send_byte(8'(cnt - 1));
          send_random_bytes(cnt * npb);
        end
        // Now and then hold the input back until every pixel has come out.
        if ($urandom_range(0, 60) == 0) drain_pixels();
      end
      quiet = 1'b0;
      phase++;
    end
  endtask

  initial begin : run_tests
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_PIXEL_BYTES;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_raw_zero_size();
    test_size_lowered();
    test_mode_switch_mid_pixel();
    test_pixel_size_lowered();
    test_random_stream();
    drain_pixels();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes over %0d register writes; checked %0d pixels,", bytes_sent,
             reg_writes, pixels_seen);
    $display("of which %0d ended an image and %0d were clipped; %0d mismatches.", ends_seen,
             clips_seen, errors);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("tga_rle_pixel_decoder_test passed");
    end else begin
      $display("tga_rle_pixel_decoder_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Run timed out with %0d pixels still expected.", pending_pixels.size());
    $display("tga_rle_pixel_decoder_test failed");
    $finish;
  end

endmodule

// ----- files.f -----
sv/tgarle_pkg.sv
sv/tga_rle_pixel_decoder.sv
sim/tga_rle_pixel_decoder_test.sv
